/* rtl/core/planar_bearing_angles_core_assert.svh */
// Assertion macros shared by the planar bearing angles core.
`ifndef PLANAR_BEARING_ANGLES_CORE_ASSERT_SVH
`define PLANAR_BEARING_ANGLES_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define PBA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define PBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pba_pkg.sv */
// Types, constants and the arctangent table of the planar bearing angles core.
`timescale 1ns / 1ps

package pba_pkg;

    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 2;
    localparam int ANGLE_W   = 16;
    localparam int ITER      = 16;
    localparam int NORM_BIT  = 48;
    localparam int SHIFT_W   = 6;
    localparam int X_W       = NORM_BIT + 4;
    localparam int Z_W       = 34;
    localparam int ZW_W      = 32;
    localparam int FRAC_DROP = 16;
    localparam int RND_W     = ZW_W + 1 - FRAC_DROP;
    localparam int CFG_IDX_W = 2;
    localparam int LANE_LAT  = ITER + 5;
    localparam int PIPE_LAT  = LANE_LAT + 1;

    localparam logic signed [Z_W-1:0] PI_Z       = Z_W'(64'd1686629713);
    localparam logic signed [Z_W-1:0] TWO_PI_Z   = Z_W'(64'd3373259426);
    localparam logic [RND_W-1:0]      TWO_PI_OUT = RND_W'(51472);
    localparam logic [ANGLE_W-1:0]    MAX_ANGLE  = ANGLE_W'(51471);
    localparam logic [ZW_W:0]         ROUND_HALF = (ZW_W + 1)'(1) << (FRAC_DROP - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REF_X = 2'd0,
        REG_REF_Y = 2'd1
    } cfg_index_t;

    // Arctangent of 2^-idx in units of 2^-29 rad.
    function automatic logic [Z_W-1:0] atan_z(input int unsigned idx);
        logic [Z_W-1:0] val;
        case (idx)
            0:       val = Z_W'(421657428);
            1:       val = Z_W'(248918915);
            2:       val = Z_W'(131521918);
            3:       val = Z_W'(66762579);
            4:       val = Z_W'(33510843);
            5:       val = Z_W'(16771758);
            6:       val = Z_W'(8387925);
            7:       val = Z_W'(4194219);
            8:       val = Z_W'(2097141);
            9:       val = Z_W'(1048575);
            10:      val = Z_W'(524288);
            11:      val = Z_W'(262144);
            12:      val = Z_W'(131072);
            13:      val = Z_W'(65536);
            14:      val = Z_W'(32768);
            15:      val = Z_W'(16384);
            16:      val = Z_W'(8192);
            17:      val = Z_W'(4096);
            18:      val = Z_W'(2048);
            19:      val = Z_W'(1024);
            20:      val = Z_W'(512);
            21:      val = Z_W'(256);
            22:      val = Z_W'(128);
            23:      val = Z_W'(64);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

/* rtl/core/pba_obj_if.sv */
// Object centroid request channel.
`timescale 1ns / 1ps

interface pba_obj_if;
    import pba_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] obj_x;
    logic signed [COORD_W-1:0] obj_y;

    modport source (output valid, output obj_x, output obj_y, input ready);
    modport sink (input valid, input obj_x, input obj_y, output ready);
endinterface

/* rtl/core/pba_angle_if.sv */
// Bearing angle result channel.
`timescale 1ns / 1ps

interface pba_angle_if;
    import pba_pkg::*;

    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] angle_to_ref;
    logic [ANGLE_W-1:0] angle_to_origin;

    modport source (output valid, output angle_to_ref, output angle_to_origin, input ready);
    modport sink (input valid, input angle_to_ref, input angle_to_origin, output ready);
endinterface

/* rtl/core/pba_cfg_if.sv */
// Configuration register write channel.
`timescale 1ns / 1ps

interface pba_cfg_if;
    import pba_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COORD_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/pba_bearing.sv */
// Pipelined CORDIC lane that turns one vector into a bearing angle in [0, 2*pi).
`timescale 1ns / 1ps

module pba_bearing (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [pba_pkg::DIFF_W-1:0]   dx,
    input  logic signed [pba_pkg::DIFF_W-1:0]   dy,
    output logic        [pba_pkg::ANGLE_W-1:0]  angle
);
    import pba_pkg::*;

    logic signed [DIFF_W-1:0] s1_x_next, s1_y_next, s1_x_reg, s1_y_reg;
    logic        [DIFF_W-1:0] s1_or_next, s1_or_reg;
    logic                     s1_neg_next, s1_zero_next, s1_neg_reg, s1_zero_reg;

    logic signed [DIFF_W-1:0] s2_x_reg, s2_y_reg;
    logic        [SHIFT_W-1:0] s2_sh_next, s2_sh_reg;
    logic                     s2_neg_reg, s2_zero_reg;

    logic signed [X_W-1:0]    cx_reg [0:ITER];
    logic signed [X_W-1:0]    cy_reg [0:ITER];
    logic signed [Z_W-1:0]    cz_reg [0:ITER];
    logic                     cq_reg [0:ITER];

    logic        [ZW_W-1:0]   zw_next, zw_reg;
    logic                     zw_zero_reg;
    logic        [RND_W-1:0]  rnd;
    logic        [ANGLE_W-1:0] angle_next, angle_reg;

    // A vector with negative x is turned by pi so CORDIC works in the right half plane.
    always_comb
    begin
        s1_neg_next  = dx[DIFF_W-1];
        s1_zero_next = (dx == '0) && (dy == '0);
        s1_x_next    = s1_neg_next ? -dx : dx;
        s1_y_next    = s1_neg_next ? -dy : dy;
        s1_or_next   = DIFF_W'(s1_x_next)
                     | (s1_y_next[DIFF_W-1] ? DIFF_W'(-s1_y_next) : DIFF_W'(s1_y_next));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x_reg    <= s1_x_next;
            s1_y_reg    <= s1_y_next;
            s1_or_reg   <= s1_or_next;
            s1_neg_reg  <= s1_neg_next;
            s1_zero_reg <= s1_zero_next;
        end
    end

    // The leading one of both magnitudes sets the doubling count.
    always_comb
    begin
        s2_sh_next = SHIFT_W'(NORM_BIT);
        for (int i = 0; i < DIFF_W; i++)
        begin
            if (s1_or_reg[i])
            begin
                s2_sh_next = (i >= NORM_BIT) ? '0 : SHIFT_W'(NORM_BIT - i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_x_reg    <= s1_x_reg;
            s2_y_reg    <= s1_y_reg;
            s2_sh_reg   <= s2_sh_next;
            s2_neg_reg  <= s1_neg_reg;
            s2_zero_reg <= s1_zero_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0] <= X_W'(s2_x_reg) << s2_sh_reg;
            cy_reg[0] <= X_W'(s2_y_reg) << s2_sh_reg;
            cz_reg[0] <= s2_neg_reg ? PI_Z : '0;
            cq_reg[0] <= s2_zero_reg;
        end
    end

    for (genvar k = 0; k < ITER; k++)
    begin : g_iter
        logic signed [X_W-1:0] xs, ys, cx_next, cy_next;
        logic signed [Z_W-1:0] cz_next;

        always_comb
        begin
            xs      = cx_reg[k] >>> k;
            ys      = cy_reg[k] >>> k;
            cx_next = cx_reg[k];
            cy_next = cy_reg[k];
            cz_next = cz_reg[k];
            if (cy_reg[k][X_W-1])
            begin
                cx_next = cx_reg[k] - ys;
                cy_next = cy_reg[k] + xs;
                cz_next = cz_reg[k] - Z_W'(atan_z(k));
            end
            else if (cy_reg[k] != '0)
            begin
                cx_next = cx_reg[k] + ys;
                cy_next = cy_reg[k] - xs;
                cz_next = cz_reg[k] + Z_W'(atan_z(k));
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cx_reg[k+1] <= cx_next;
                cy_reg[k+1] <= cy_next;
                cz_reg[k+1] <= cz_next;
                cq_reg[k+1] <= cq_reg[k];
            end
        end
    end

    always_comb
    begin
        if (cz_reg[ITER][Z_W-1])
        begin
            zw_next = ZW_W'(cz_reg[ITER] + TWO_PI_Z);
        end
        else if (cz_reg[ITER] >= TWO_PI_Z)
        begin
            zw_next = ZW_W'(cz_reg[ITER] - TWO_PI_Z);
        end
        else
        begin
            zw_next = ZW_W'(cz_reg[ITER]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zw_reg      <= zw_next;
            zw_zero_reg <= cq_reg[ITER];
        end
    end

    // An angle that rounds up to a full turn folds back to zero.
    always_comb
    begin
        rnd = RND_W'(((ZW_W + 1)'(zw_reg) + ROUND_HALF) >> FRAC_DROP);
        if (zw_zero_reg)
        begin
            angle_next = '0;
        end
        else if (rnd >= TWO_PI_OUT)
        begin
            angle_next = ANGLE_W'(rnd - TWO_PI_OUT);
        end
        else
        begin
            angle_next = ANGLE_W'(rnd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

/* rtl/core/planar_bearing_angles_core.sv */
// Top level of the planar bearing angles core.
//
//  Channel    | Role   | Payload
//  -----------+--------+-----------------------------------------
//  cfg        | sink   | index, data (reference x and y)
//  obj_in     | sink   | obj_x, obj_y
//  angle_out  | source | angle_to_ref, angle_to_origin
//
// One request is taken per cycle unless a result waits on angle_out.
// The pipeline is the difference stage followed, in each of the two lanes,
// which run in lockstep, by the 16 CORDIC stages and the normalization and wrap stages.
// Reset clears the reference point and the valid bits of every stage.
// While a result waits on angle_out the whole pipeline holds.
`timescale 1ns / 1ps
`include "planar_bearing_angles_core_assert.svh"

module planar_bearing_angles_core (
    input  logic        clk,
    input  logic        rst_n,
    pba_cfg_if.sink     cfg,
    pba_obj_if.sink     obj_in,
    pba_angle_if.source angle_out
);
    import pba_pkg::*;

    logic signed [COORD_W-1:0] ref_x_reg, ref_x_next, ref_y_reg, ref_y_next;
    logic                      en;
    logic        [PIPE_LAT-1:0] vld_reg, vld_next;
    logic signed [DIFF_W-1:0]  rx_next, ry_next, rx_reg, ry_reg, ox_reg, oy_reg;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        ref_x_next = ref_x_reg;
        ref_y_next = ref_y_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_REF_X: ref_x_next = cfg.data;
                REG_REF_Y: ref_y_next = cfg.data;
                default:
                begin
                    ref_x_next = ref_x_reg;
                    ref_y_next = ref_y_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_x_reg <= '0;
            ref_y_reg <= '0;
        end
        else
        begin
            ref_x_reg <= ref_x_next;
            ref_y_reg <= ref_y_next;
        end
    end

    assign en           = !vld_reg[PIPE_LAT-1] || angle_out.ready;
    assign obj_in.ready = en;
    assign vld_next     = {vld_reg[PIPE_LAT-2:0], obj_in.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        rx_next = DIFF_W'(obj_in.obj_x) - DIFF_W'(ref_x_reg);
        ry_next = DIFF_W'(obj_in.obj_y) - DIFF_W'(ref_y_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            ox_reg <= DIFF_W'(obj_in.obj_x);
            oy_reg <= DIFF_W'(obj_in.obj_y);
        end
    end

    pba_bearing u_ref_lane (
        .clk   (clk),
        .en    (en),
        .dx    (rx_reg),
        .dy    (ry_reg),
        .angle (angle_out.angle_to_ref)
    );

    pba_bearing u_origin_lane (
        .clk   (clk),
        .en    (en),
        .dx    (ox_reg),
        .dy    (oy_reg),
        .angle (angle_out.angle_to_origin)
    );

    assign angle_out.valid = vld_reg[PIPE_LAT-1];

    `PBA_ASSERT_NOW(a_stall_blocks_input, clk, rst_n, angle_out.valid && !angle_out.ready, !obj_in.ready, "input taken while the result is stalled")
    `PBA_ASSERT_NOW(a_angle_in_range, clk, rst_n, angle_out.valid, angle_out.angle_to_ref <= MAX_ANGLE && angle_out.angle_to_origin <= MAX_ANGLE, "angle outside one turn")
    `PBA_ASSERT_NEXT(a_ref_x_write, clk, rst_n, cfg.valid && cfg.ready && cfg.index == REG_REF_X, ref_x_reg == $past(cfg.data), "reference x not written")

endmodule
